/* rtl/pfne_pkg.sv */
// ----------------------------------------------------------------------------
// pfne_pkg
// Shared types and constants of the polynomial normal-equation accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfne_pkg;

    // Step counter covers power index 0..2*MAX_DEGREE for degrees up to six.
    localparam int K_W        = 4;
    // Row and column indexes of an emitted entry.
    localparam int IDX_W      = 3;
    localparam int DEGREE_W   = 3;
    localparam int RIDGE_W    = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RIDGE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_POW   = 4'b0010,
        ST_CROSS = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic             load;        // transaction accepted this cycle
        logic             pow_acc;     // add current power to power sum k
        logic             cross_acc;   // add y*x^k to cross sum k
        logic             mul_to_prod; // multiplier forms y*x^k
        logic             mul_to_pow;  // multiplier forms the next power
        logic             emit;        // one output entry this cycle
        logic [K_W-1:0]   k;
        logic             kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last_entry;
        logic             clear;
    } seq_ctl_t;

endpackage

`default_nettype wire

/* rtl/pfne_mul.sv */
// ----------------------------------------------------------------------------
// pfne_mul
// Shared signed multiplier with round-half-up to the sample fraction width.
// ----------------------------------------------------------------------------
`default_nettype none

module pfne_mul #(
    parameter int W = 17,
    parameter int F = 15
) (
    input  wire logic signed [W-1:0] a,
    input  wire logic signed [W-1:0] b,
    output logic signed [W-1:0]      rounded
);

    localparam int PW = 2 * W;
    localparam logic signed [PW-1:0] HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] biased;
    logic signed [PW-1:0] shifted;

    assign prod    = a * b;
    assign biased  = prod + HALF;
    assign shifted = biased >>> F;
    // Magnitudes never exceed 1.0, so the low W bits hold the whole value.
    assign rounded = shifted[W-1:0];

endmodule

`default_nettype wire

/* rtl/pfne_sat_add.sv */
// ----------------------------------------------------------------------------
// pfne_sat_add
// Shared adder that clamps its sum to the signed accumulator range.
// ----------------------------------------------------------------------------
`default_nettype none

module pfne_sat_add #(
    parameter int ACC_W = 40,
    parameter int B_W   = 40
) (
    input  wire logic signed [ACC_W-1:0] a,
    input  wire logic signed [B_W-1:0]   b,
    output logic signed [ACC_W-1:0]      sum
);

    localparam int ADD_W = B_W + 1;
    localparam logic signed [ADD_W-1:0] SAT_MAX =
        {{(ADD_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic signed [ADD_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [ADD_W-1:0] a_ext;
    logic signed [ADD_W-1:0] b_ext;
    logic signed [ADD_W-1:0] wide;

    assign a_ext = {{(ADD_W-ACC_W){a[ACC_W-1]}}, a};
    assign b_ext = {b[B_W-1], b};
    assign wide  = a_ext + b_ext;

    always_comb
    begin
        if (wide > SAT_MAX)
        begin
            sum = SAT_MAX[ACC_W-1:0];
        end
        else if (wide < SAT_MIN)
        begin
            sum = SAT_MIN[ACC_W-1:0];
        end
        else
        begin
            sum = wide[ACC_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/pfne_ctrl.sv */
// ----------------------------------------------------------------------------
// pfne_ctrl
// Sequencer that steps the shared units through accumulation and output.
// ----------------------------------------------------------------------------
`default_nettype none

module pfne_ctrl
    import pfne_pkg::*;
#(
    parameter int MAX_DEGREE = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             last_sample,
    input  wire logic [IDX_W-1:0] m,
    output logic                  busy,
    output seq_ctl_t              ctl
);

    localparam logic [K_W-1:0] K_CROSS_MAX = K_W'(MAX_DEGREE);
    localparam logic [K_W-1:0] K_LAST      = K_W'(2 * MAX_DEGREE);

    state_t           state_reg, state_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic             kind_reg, kind_next;
    logic             last_reg, last_next;

    logic in_pow, in_cross, in_emit, has_cross, final_entry;

    assign in_pow      = (state_reg == ST_POW);
    assign in_cross    = (state_reg == ST_CROSS);
    assign in_emit     = (state_reg == ST_EMIT);
    assign has_cross   = (k_reg <= K_CROSS_MAX);
    assign final_entry = in_emit && kind_reg && (row_reg == m);

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        ctl.load        = start && (state_reg == ST_IDLE);
        ctl.pow_acc     = in_pow;
        ctl.cross_acc   = in_cross;
        ctl.mul_to_prod = in_pow && has_cross;
        ctl.mul_to_pow  = (in_pow && !has_cross) || in_cross;
        ctl.emit        = in_emit;
        ctl.k           = k_reg;
        ctl.kind        = kind_reg;
        ctl.row         = row_reg;
        ctl.col         = col_reg;
        ctl.last_entry  = final_entry;
        ctl.clear       = final_entry;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    k_next     = '0;
                    last_next  = last_sample;
                    state_next = ST_POW;
                end
            end
            ST_POW:
            begin
                if (has_cross)
                begin
                    state_next = ST_CROSS;
                end
                else if (k_reg == K_LAST)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    kind_next  = 1'b0;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_CROSS:
            begin
                k_next     = k_reg + 1'b1;
                state_next = ST_POW;
            end
            ST_EMIT:
            begin
                if (!kind_reg)
                begin
                    if (col_reg == m)
                    begin
                        col_next = '0;
                        if (row_reg == m)
                        begin
                            row_next  = '0;
                            kind_next = 1'b1;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                else if (row_reg == m)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            kind_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            kind_reg  <= kind_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/poly_fit_normal_equation_accumulator.sv */
// ----------------------------------------------------------------------------
// poly_fit_normal_equation_accumulator
// Accumulates power sums and cross sums of (x,y) samples for a least-squares
// polynomial fit and emits the normal equations on the last sample.
// ----------------------------------------------------------------------------
// Usage: a sample transaction is taken at a clock edge with start high and
// busy low. One rounding multiplier and one saturating adder, shared under a
// small sequencer, do all the work: every power of x is added in ST_POW,
// and the first MAX_DEGREE+1 powers also pass through ST_CROSS for the y*x^k
// term; busy stays high from an accept until those steps are done, and a new
// sample is taken only after busy has gone low again.
// On a sample flagged last, (m+1)^2 matrix entries in row-major order and
// then m+1 vector entries follow, one per cycle, each shown for a single
// cycle with result_valid high; each is formed in ST_EMIT, then registered
// for output, and busy stays high until the final entry has been formed.
// last_result marks the final entry, after which all sums are zero again.
// The receiver cannot stall this stream.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// belong in idle periods. Reset clears all sums, sets degree to 1 and ridge
// to 0; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_fit_normal_equation_accumulator
    import pfne_pkg::*;
#(
    parameter int MAX_DEGREE   = 4,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 40
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_y,
    input  wire logic                           last_sample,
    input  wire logic                           cfg_we,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          cfg_wdata,
    output logic                                result_valid,
    output logic                                entry_kind,
    output logic [IDX_W-1:0]                    row_index,
    output logic [IDX_W-1:0]                    col_index,
    output logic signed [ACC_WIDTH-1:0]         entry_value,
    output logic                                last_result
);

    localparam int F       = SAMPLE_WIDTH - 1;
    localparam int PWR_W   = SAMPLE_WIDTH + 1;
    localparam int NPOW    = 2 * MAX_DEGREE + 1;
    localparam int NCROSS  = MAX_DEGREE + 1;
    localparam int PIDX_W  = $clog2(NPOW);
    localparam int CIDX_W  = $clog2(NCROSS);
    localparam int B_W     = (ACC_WIDTH > 33) ? ACC_WIDTH : 33;
    localparam logic signed [PWR_W-1:0] ONE = {2'b01, {F{1'b0}}};
    localparam logic [IDX_W-1:0] M_MAX = IDX_W'(MAX_DEGREE);

    seq_ctl_t ctl;

    logic [DEGREE_W-1:0] degree_reg;
    logic [RIDGE_W-1:0]  ridge_reg;
    logic [IDX_W-1:0]    m;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [PWR_W-1:0]        p_reg;
    logic signed [PWR_W-1:0]        prod_reg;
    logic signed [ACC_WIDTH-1:0]    power_sums_reg [NPOW];
    logic signed [ACC_WIDTH-1:0]    cross_sums_reg [NCROSS];

    logic signed [PWR_W-1:0]     mul_b;
    logic signed [PWR_W-1:0]     mul_out;
    logic signed [ACC_WIDTH-1:0] add_a;
    logic signed [B_W-1:0]       add_b;
    logic signed [ACC_WIDTH-1:0] add_sum;
    logic [K_W-1:0]              rc_sum;
    logic [PIDX_W-1:0]           k_pow;
    logic [CIDX_W-1:0]           k_cross;

    logic                        result_valid_reg;
    logic                        entry_kind_reg;
    logic [IDX_W-1:0]            row_index_reg;
    logic [IDX_W-1:0]            col_index_reg;
    logic signed [ACC_WIDTH-1:0] entry_value_reg;
    logic                        last_result_reg;

    // A degree above the built maximum is treated as the maximum.
    assign m = (degree_reg > M_MAX) ? M_MAX : degree_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= DEGREE_W'(1);
            ridge_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEGREE: degree_reg <= cfg_wdata[DEGREE_W-1:0];
                REG_RIDGE:  ridge_reg  <= cfg_wdata[RIDGE_W-1:0];
                default:    ;
            endcase
        end
    end

    pfne_ctrl #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_sample(last_sample),
        .m          (m),
        .busy       (busy),
        .ctl        (ctl)
    );

    assign mul_b = ctl.mul_to_prod ? {y_reg[SAMPLE_WIDTH-1], y_reg}
                                   : {x_reg[SAMPLE_WIDTH-1], x_reg};

    pfne_mul #(
        .W(PWR_W),
        .F(F)
    ) u_mul (
        .a      (p_reg),
        .b      (mul_b),
        .rounded(mul_out)
    );

    assign k_pow   = ctl.k[PIDX_W-1:0];
    assign k_cross = ctl.k[CIDX_W-1:0];
    assign rc_sum  = K_W'(ctl.row) + K_W'(ctl.col);

    always_comb
    begin
        add_a = '0;
        add_b = '0;
        if (ctl.pow_acc)
        begin
            add_a = power_sums_reg[k_pow];
            add_b = B_W'(p_reg);
        end
        else if (ctl.cross_acc)
        begin
            add_a = cross_sums_reg[k_cross];
            add_b = B_W'(prod_reg);
        end
        else if (ctl.emit && !ctl.kind)
        begin
            add_a = power_sums_reg[rc_sum[PIDX_W-1:0]];
            if (ctl.row == ctl.col)
            begin
                add_b = {{(B_W-RIDGE_W){1'b0}}, ridge_reg};
            end
        end
        else if (ctl.emit)
        begin
            add_a = cross_sums_reg[ctl.row[CIDX_W-1:0]];
        end
    end

    pfne_sat_add #(
        .ACC_W(ACC_WIDTH),
        .B_W  (B_W)
    ) u_add (
        .a  (add_a),
        .b  (add_b),
        .sum(add_sum)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg <= sample_x;
            y_reg <= sample_y;
            p_reg <= ONE;
        end
        else if (ctl.mul_to_pow)
        begin
            p_reg <= mul_out;
        end
        if (ctl.mul_to_prod)
        begin
            prod_reg <= mul_out;
        end
    end

    // The final entry reads its sum combinationally before the clear lands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPOW; i++)
            begin
                power_sums_reg[i] <= '0;
            end
            for (int i = 0; i < NCROSS; i++)
            begin
                cross_sums_reg[i] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < NPOW; i++)
            begin
                power_sums_reg[i] <= '0;
            end
            for (int i = 0; i < NCROSS; i++)
            begin
                cross_sums_reg[i] <= '0;
            end
        end
        else if (ctl.pow_acc)
        begin
            power_sums_reg[k_pow] <= add_sum;
        end
        else if (ctl.cross_acc)
        begin
            cross_sums_reg[k_cross] <= add_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            entry_kind_reg  <= ctl.kind;
            row_index_reg   <= ctl.row;
            col_index_reg   <= ctl.kind ? '0 : ctl.col;
            entry_value_reg <= add_sum;
            last_result_reg <= ctl.last_entry;
        end
    end

    assign result_valid = result_valid_reg;
    assign entry_kind   = entry_kind_reg;
    assign row_index    = row_index_reg;
    assign col_index    = col_index_reg;
    assign entry_value  = entry_value_reg;
    assign last_result  = last_result_reg;

    a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> result_valid_reg)
        else $error("output entry computed but no strobe followed");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && last_result_reg) |=> !result_valid_reg)
        else $error("entries continued after the final entry");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> !busy)
        else $error("block still busy after the sums were cleared");

    a_load_first_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (ctl.pow_acc && (ctl.k == '0)))
        else $error("accepted sample did not start at power zero");

    a_one_unit_user: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.pow_acc, ctl.cross_acc, ctl.emit}))
        else $error("shared adder claimed by two steps at once");

endmodule

`default_nettype wire
